// ===== hw/rtl/pcfs_pkg.sv =====
// ----------------------------------------------------------------------------
// Periodic CAN frame scheduler package
// Shared widths, item codes and the table entry type.
// ----------------------------------------------------------------------------
package pcfs_pkg;

    // Field widths of one table entry.
    localparam int TIME_W = 32;
    localparam int PER_W  = 14;
    localparam int ID_W   = 29;
    localparam int DATA_W = 64;
    localparam int KIND_W = 2;

    // Raw identifier word layout.
    localparam int RAW_W   = 32;
    localparam int BUS_BIT = 29;

    // Shortest period that is stored.
    localparam logic [PER_W-1:0] MIN_PERIOD = PER_W'(10);

    // At most this many frames leave per tick.
    localparam int MAX_RESULTS = 16;
    localparam int HIT_W       = $clog2(MAX_RESULTS + 1);

    // Default table depth.
    localparam int DEF_MAX_MSGS = 16;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    // One table entry as it travels along the cell row.
    typedef struct packed {
        logic [TIME_W-1:0] last_sent;
        logic [PER_W-1:0]  period;
        logic              bus;
        logic [ID_W-1:0]   id;
        logic [DATA_W-1:0] data;
    } t_entry;

endpackage

// ===== hw/rtl/pcfs_cell.sv =====
// ----------------------------------------------------------------------------
// Periodic CAN frame scheduler cell
// Holds one table entry. During a scan it takes the entry of its neighbor,
// so the row rotates one place per cycle; when idle it can be written.
// ----------------------------------------------------------------------------
module pcfs_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_shift,
    input  pcfs_pkg::t_entry           i_shift_in,
    input  logic                       i_wr,
    input  logic [pcfs_pkg::PER_W-1:0] i_wr_period,
    input  logic                       i_wr_bus,
    input  logic [pcfs_pkg::ID_W-1:0]  i_wr_id,
    input  logic [pcfs_pkg::DATA_W-1:0] i_wr_data,
    output pcfs_pkg::t_entry           o_entry
);

    logic [pcfs_pkg::TIME_W-1:0] r_last_sent;
    logic [pcfs_pkg::PER_W-1:0]  r_period;
    logic                        r_bus;
    logic [pcfs_pkg::ID_W-1:0]   r_id;
    logic [pcfs_pkg::DATA_W-1:0] r_data;

    // Last sent time is cleared by reset; an add leaves it alone.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_sent <= '0;
        end else if (i_shift) begin
            r_last_sent <= i_shift_in.last_sent;
        end
    end

    // Frame fields hold no reset value.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_period <= i_shift_in.period;
            r_bus    <= i_shift_in.bus;
            r_id     <= i_shift_in.id;
            r_data   <= i_shift_in.data;
        end else if (i_wr) begin
            r_period <= i_wr_period;
            r_bus    <= i_wr_bus;
            r_id     <= i_wr_id;
            r_data   <= i_wr_data;
        end
    end

    assign o_entry = '{last_sent: r_last_sent, period: r_period, bus: r_bus,
                       id: r_id, data: r_data};

endmodule

// ===== hw/rtl/periodic_can_frame_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// Periodic CAN frame scheduler core
// A row of MAX_MSGS cells holds the frame table. A tick rotates the row once
// through the head, where each entry is checked and, when due, sent.
// Add and clear items never make the block busy; it stays free for the next item.
// A tick with ignition on and a non-empty table stays busy while the row passes
// the head once, cell by cell, and then in a flush state for the held frame;
// the final frame appears in the same cycle that busy falls. The receiver cannot stall.
// Synchronous active-low reset empties the table and zeroes all last sent times.
// ----------------------------------------------------------------------------
module periodic_can_frame_scheduler_core #(
    parameter int MAX_MSGS = pcfs_pkg::DEF_MAX_MSGS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [pcfs_pkg::KIND_W-1:0]   i_kind,
    input  logic [pcfs_pkg::TIME_W-1:0]   i_now_ms,
    input  logic                          i_ignition_on,
    input  logic [pcfs_pkg::RAW_W-1:0]    i_raw_id,
    input  logic [pcfs_pkg::PER_W-1:0]    i_period_ms,
    input  logic [pcfs_pkg::DATA_W-1:0]   i_payload,
    output logic                          o_strobe,
    output logic                          o_bus_select,
    output logic [pcfs_pkg::ID_W-1:0]     o_frame_id,
    output logic [pcfs_pkg::DATA_W-1:0]   o_frame_data,
    output logic                          o_last
);

    localparam int CNT_W = $clog2(MAX_MSGS + 1);
    localparam int IDX_W = (MAX_MSGS > 1) ? $clog2(MAX_MSGS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    t_state                        r_state;
    logic [CNT_W-1:0]              r_count;
    logic [IDX_W-1:0]              r_idx;
    logic [pcfs_pkg::HIT_W-1:0]    r_hits;
    logic [pcfs_pkg::TIME_W-1:0]   r_now;
    logic                          r_pend_v;
    logic                          r_pend_bus;
    logic [pcfs_pkg::ID_W-1:0]     r_pend_id;
    logic [pcfs_pkg::DATA_W-1:0]   r_pend_data;
    logic                          r_strobe;
    logic                          r_bus;
    logic [pcfs_pkg::ID_W-1:0]     r_id;
    logic [pcfs_pkg::DATA_W-1:0]   r_data;
    logic                          r_last;

    pcfs_pkg::t_entry              cell_q [MAX_MSGS];
    pcfs_pkg::t_entry              head_upd;
    logic [pcfs_pkg::TIME_W-1:0]   elapsed;
    logic                          scan;
    logic                          due;
    logic                          add_acc;
    logic [pcfs_pkg::PER_W-1:0]    wr_period;

    // Handshake and add decoding.
    assign busy      = (r_state != ST_IDLE);
    assign scan      = (r_state == ST_SCAN);
    assign add_acc   = start && !busy && (i_kind == pcfs_pkg::KIND_ADD) &&
                       (r_count < CNT_W'(MAX_MSGS));
    assign wr_period = (i_period_ms < pcfs_pkg::MIN_PERIOD) ? pcfs_pkg::MIN_PERIOD
                                                            : i_period_ms;

    // Head check: the entry now in cell 0 is due when its wrapped age exceeds
    // its period, it lies inside the table and the per-tick limit is not met.
    always_comb begin
        elapsed  = r_now - cell_q[0].last_sent;
        due      = scan && (CNT_W'(r_idx) < r_count) &&
                   (elapsed > {{(pcfs_pkg::TIME_W - pcfs_pkg::PER_W){1'b0}},
                               cell_q[0].period}) &&
                   (r_hits != pcfs_pkg::HIT_W'(pcfs_pkg::MAX_RESULTS));
        head_upd = cell_q[0];
        if (due) begin
            head_upd.last_sent = r_now;
        end
    end

    // Row of cells; the head feeds back into the tail.
    for (genvar k = 0; k < MAX_MSGS; k++) begin : g_cell
        pcfs_pkg::t_entry shift_in;
        if (k == MAX_MSGS - 1) begin : g_tail
            assign shift_in = head_upd;
        end else begin : g_mid
            assign shift_in = cell_q[k+1];
        end
        pcfs_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_shift     (scan),
            .i_shift_in  (shift_in),
            .i_wr        (add_acc && (r_count == CNT_W'(k))),
            .i_wr_period (wr_period),
            .i_wr_bus    (i_raw_id[pcfs_pkg::BUS_BIT]),
            .i_wr_id     (i_raw_id[pcfs_pkg::ID_W-1:0]),
            .i_wr_data   (i_payload),
            .o_entry     (cell_q[k])
        );
    end

    // Control sequencer. A due frame is held until the next due frame or the flush
    // so the final one of a tick can be marked once the scan has passed all cells.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_hits   <= '0;
            r_pend_v <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        case (i_kind)
                            pcfs_pkg::KIND_ADD: begin
                                if (add_acc) begin
                                    r_count <= r_count + CNT_W'(1);
                                end
                            end
                            pcfs_pkg::KIND_CLEAR: begin
                                r_count <= '0;
                            end
                            pcfs_pkg::KIND_TICK: begin
                                if (i_ignition_on && (r_count != '0)) begin
                                    r_now    <= i_now_ms;
                                    r_idx    <= '0;
                                    r_hits   <= '0;
                                    r_pend_v <= 1'b0;
                                    r_state  <= ST_SCAN;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (due) begin
                        r_hits <= r_hits + pcfs_pkg::HIT_W'(1);
                        if (r_pend_v) begin
                            r_strobe <= 1'b1;
                            r_bus    <= r_pend_bus;
                            r_id     <= r_pend_id;
                            r_data   <= r_pend_data;
                            r_last   <= 1'b0;
                        end
                        r_pend_v    <= 1'b1;
                        r_pend_bus  <= cell_q[0].bus;
                        r_pend_id   <= cell_q[0].id;
                        r_pend_data <= cell_q[0].data;
                    end
                    if (r_idx == IDX_W'(MAX_MSGS - 1)) begin
                        r_state <= ST_FLUSH;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                ST_FLUSH: begin
                    if (r_pend_v) begin
                        r_strobe <= 1'b1;
                        r_bus    <= r_pend_bus;
                        r_id     <= r_pend_id;
                        r_data   <= r_pend_data;
                        r_last   <= 1'b1;
                    end
                    r_pend_v <= 1'b0;
                    r_state  <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_strobe     = r_strobe;
    assign o_bus_select = r_bus;
    assign o_frame_id   = r_id;
    assign o_frame_data = r_data;
    assign o_last       = r_last;

endmodule

// ===== hw/rtl/pcfs_checker.sv =====
// ----------------------------------------------------------------------------
// Periodic CAN frame scheduler checker
// Port-level checks of the item sequencing, bound to the core.
// ----------------------------------------------------------------------------
module pcfs_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [pcfs_pkg::KIND_W-1:0] i_kind,
    input logic                        i_ignition_on,
    input logic                        o_strobe,
    input logic                        o_last
);

    // Reset leaves the block free and silent.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_strobe)
        else $error("block busy or sending after reset");

    // Add and clear items never occupy the block.
    a_cmd_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_kind != pcfs_pkg::KIND_TICK) |=> !busy)
        else $error("add or clear item made the block busy");

    // A tick with ignition off does nothing.
    a_ign_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_kind == pcfs_pkg::KIND_TICK) && !i_ignition_on
        |=> !busy)
        else $error("tick with ignition off started a scan");

    // The final frame of a tick comes once the block is free, the others before.
    a_last_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_last == !busy))
        else $error("final frame mark does not match scan end");

    // Nothing follows the final frame of a tick directly.
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |=> !o_strobe)
        else $error("frame sent right after the final frame");

endmodule

bind periodic_can_frame_scheduler_core pcfs_checker u_pcfs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_kind        (i_kind),
    .i_ignition_on (i_ignition_on),
    .o_strobe      (o_strobe),
    .o_last        (o_last)
);

// ===== tb/tb_periodic_can_frame_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// Periodic CAN frame scheduler core testbench
// Drives tick, add, clear and unused items through the start/busy handshake.
// A behavioral copy of the frame table predicts every frame that a tick sends.
// Each strobed frame is compared field by field with the oldest prediction.
// A short directed table covers the corner cases, and random traffic follows.
// ----------------------------------------------------------------------------
module tb_periodic_can_frame_scheduler_core;

    localparam int TABLE_DEPTH  = pcfs_pkg::DEF_MAX_MSGS;
    localparam int RANDOM_ITEMS = 100;
    localparam int QUIET_LIMIT  = 2000;
    localparam int MAX_GAP      = 40;
    localparam logic [pcfs_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

    // One input item, as it is presented on the ports.
    typedef struct packed {
        logic [pcfs_pkg::KIND_W-1:0] kind;
        logic [pcfs_pkg::TIME_W-1:0] now_ms;
        logic                        ign;
        logic [pcfs_pkg::RAW_W-1:0]  raw_id;
        logic [pcfs_pkg::PER_W-1:0]  period_ms;
        logic [pcfs_pkg::DATA_W-1:0] payload;
    } t_sched_item;

    // One frame as it leaves the block.
    typedef struct packed {
        logic                        bus;
        logic [pcfs_pkg::ID_W-1:0]   id;
        logic [pcfs_pkg::DATA_W-1:0] data;
        logic                        last;
    } t_frame;

    // Directed row: want_n of -1 leaves the result to the predictor.
    typedef struct {
        t_sched_item item;
        int          want_n;
        t_frame      want_frame;
    } t_dir_row;

    localparam t_frame NO_FRAME = '0;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_sched_item cur_item = '0;
    int          cur_want_n = -1;
    t_frame      cur_want_frame = '0;

    logic                          o_strobe;
    logic                          o_bus_select;
    logic [pcfs_pkg::ID_W-1:0]     o_frame_id;
    logic [pcfs_pkg::DATA_W-1:0]   o_frame_data;
    logic                          o_last;

    // Predicted frame table.
    int                          fill = 0;
    logic [pcfs_pkg::TIME_W-1:0] ent_last   [TABLE_DEPTH];
    logic [pcfs_pkg::PER_W-1:0]  ent_period [TABLE_DEPTH];
    logic                        ent_bus    [TABLE_DEPTH];
    logic [pcfs_pkg::ID_W-1:0]   ent_id     [TABLE_DEPTH];
    logic [pcfs_pkg::DATA_W-1:0] ent_data   [TABLE_DEPTH];
    t_frame                      burst      [pcfs_pkg::MAX_RESULTS];

    t_frame frames_due[$];
    int     err_cnt = 0;
    int     quiet = 0;
    int     frames_seen = 0;
    int     n_ticks = 0;
    int     n_adds = 0;
    int     n_clears = 0;
    int     n_unused = 0;
    int     widest_burst = 0;

    periodic_can_frame_scheduler_core #(
        .MAX_MSGS(TABLE_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (cur_item.kind),
        .i_now_ms      (cur_item.now_ms),
        .i_ignition_on (cur_item.ign),
        .i_raw_id      (cur_item.raw_id),
        .i_period_ms   (cur_item.period_ms),
        .i_payload     (cur_item.payload),
        .o_strobe      (o_strobe),
        .o_bus_select  (o_bus_select),
        .o_frame_id    (o_frame_id),
        .o_frame_data  (o_frame_data),
        .o_last        (o_last)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Applies one item to the predicted table and fills burst with the frames
    // that it sends. Returns the number of frames.
    function automatic int schedule_item(input t_sched_item it);
        int n;
        logic [pcfs_pkg::TIME_W-1:0] elapsed;
        n = 0;
        case (it.kind)
            pcfs_pkg::KIND_ADD: begin
                // A full table drops the add; the slot keeps its last sent time.
                if (fill < TABLE_DEPTH) begin
                    ent_id[fill]     = it.raw_id[pcfs_pkg::ID_W-1:0];
                    ent_bus[fill]    = it.raw_id[pcfs_pkg::BUS_BIT];
                    ent_period[fill] = (it.period_ms < pcfs_pkg::MIN_PERIOD) ?
                                       pcfs_pkg::MIN_PERIOD : it.period_ms;
                    ent_data[fill]   = it.payload;
                    fill++;
                end
            end
            pcfs_pkg::KIND_CLEAR: begin
                fill = 0;
            end
            pcfs_pkg::KIND_TICK: begin
                if (it.ign) begin
                    for (int i = 0; i < fill && n < pcfs_pkg::MAX_RESULTS; i++) begin
                        elapsed = it.now_ms - ent_last[i];
                        if (elapsed > pcfs_pkg::TIME_W'(ent_period[i])) begin
                            ent_last[i] = it.now_ms;
                            burst[n] = {ent_bus[i], ent_id[i], ent_data[i], 1'b0};
                            n++;
                        end
                    end
                end
            end
            default: ;
        endcase
        if (n > 0) begin
            burst[n-1].last = 1'b1;
        end
        return n;
    endfunction

    function automatic void check_field(input string name,
                                        input logic [pcfs_pkg::DATA_W-1:0] want,
                                        input logic [pcfs_pkg::DATA_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            err_cnt++;
        end
    endfunction

    function automatic t_dir_row row(input logic [pcfs_pkg::KIND_W-1:0] kind,
                                     input logic [pcfs_pkg::TIME_W-1:0] now_ms,
                                     input logic ign,
                                     input logic [pcfs_pkg::RAW_W-1:0] raw_id,
                                     input logic [pcfs_pkg::PER_W-1:0] period_ms,
                                     input logic [pcfs_pkg::DATA_W-1:0] payload,
                                     input int want_n, input t_frame want_frame);
        t_dir_row r;
        r.item       = {kind, now_ms, ign, raw_id, period_ms, payload};
        r.want_n     = want_n;
        r.want_frame = want_frame;
        return r;
    endfunction

    // Checks frames and predicts accepted items at each rising edge.
    always @(posedge i_clk) begin : monitor
        t_frame got;
        t_frame want;
        int n;
        bit moved;
        moved = 1'b0;
        if (i_rst_n) begin
            // Frames come from items accepted at earlier edges.
            if (o_strobe !== 1'b0) begin
                got = {o_bus_select, o_frame_id, o_frame_data, o_last};
                if (frames_due.size() == 0) begin
                    $error("frame with none expected: id %h data %h", o_frame_id,
                           o_frame_data);
                    err_cnt++;
                end else begin
                    want = frames_due.pop_front();
                    check_field("bus_select", pcfs_pkg::DATA_W'(want.bus),
                                pcfs_pkg::DATA_W'(got.bus));
                    check_field("frame_id", pcfs_pkg::DATA_W'(want.id),
                                pcfs_pkg::DATA_W'(got.id));
                    check_field("frame_data", want.data, got.data);
                    check_field("last", pcfs_pkg::DATA_W'(want.last),
                                pcfs_pkg::DATA_W'(got.last));
                end
                frames_seen++;
                moved = 1'b1;
            end
            if (start && busy === 1'b0) begin
                n = schedule_item(cur_item);
                if (n > widest_burst) widest_burst = n;
                if (cur_want_n >= 0) begin
                    if (cur_want_n == 1) frames_due.push_back(cur_want_frame);
                end else begin
                    for (int i = 0; i < n; i++) frames_due.push_back(burst[i]);
                end
                case (cur_item.kind)
                    pcfs_pkg::KIND_TICK:  n_ticks++;
                    pcfs_pkg::KIND_ADD:   n_adds++;
                    pcfs_pkg::KIND_CLEAR: n_clears++;
                    default:              n_unused++;
                endcase
                moved = 1'b1;
            end
        end
        quiet = moved ? 0 : quiet + 1;
    end

    initial begin : watchdog
        while (quiet < QUIET_LIMIT) @(posedge i_clk);
        $display("periodic_can_frame_scheduler_core: mismatch");
        $finish;
    end

    // Presents one item after gap idle cycles and returns at its accepting edge.
    task automatic issue(input t_sched_item it, input int want_n, input t_frame want_frame,
                         input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        cur_item       <= it;
        cur_want_n     <= want_n;
        cur_want_frame <= want_frame;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    // Holds the sender off until every predicted frame has been seen.
    task automatic wait_idle();
        start <= 1'b0;
        do @(negedge i_clk); while (frames_due.size() != 0);
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_dir_row    dir_rows[$];
        t_sched_item it;
        int          idle_pct [4];
        int          counted;
        int          gap;
        int          r;
        logic [pcfs_pkg::TIME_W-1:0] sim_ms;

        for (int i = 0; i < TABLE_DEPTH; i++) ent_last[i] = '0;

        // Directed table: empty table, unused kind, identifier and period extremes,
        // equal elapsed time, ignition off, time wrap, clear, full table.
        dir_rows.push_back(row(pcfs_pkg::KIND_TICK, 32'd5, 1'b1, '0, '0, '0, 0, NO_FRAME));
        dir_rows.push_back(row(KIND_UNUSED, '1, 1'b1, '1, '1, '1, 0, NO_FRAME));
        dir_rows.push_back(row(pcfs_pkg::KIND_ADD, '0, 1'b0, 32'hffff_ffff, 14'd0, '1, 0,
                               NO_FRAME));
        dir_rows.push_back(row(pcfs_pkg::KIND_TICK, 32'd10, 1'b1, '0, '0, '0, 0, NO_FRAME));
        dir_rows.push_back(row(pcfs_pkg::KIND_TICK, 32'd11, 1'b0, '0, '0, '0, 0, NO_FRAME));
        dir_rows.push_back(row(pcfs_pkg::KIND_TICK, 32'd11, 1'b1, '0, '0, '0, 1,
                               {1'b1, 29'h1fff_ffff, 64'hffff_ffff_ffff_ffff, 1'b1}));
        dir_rows.push_back(row(pcfs_pkg::KIND_ADD, '1, 1'b1, 32'hdfff_ffff, 14'd16383,
                               64'h0123_4567_89ab_cdef, 0, NO_FRAME));
        dir_rows.push_back(row(pcfs_pkg::KIND_TICK, 32'hffff_ffff, 1'b1, '0, '0, '0, -1,
                               NO_FRAME));
        dir_rows.push_back(row(pcfs_pkg::KIND_TICK, 32'd3, 1'b1, '0, '0, '0, -1, NO_FRAME));
        dir_rows.push_back(row(pcfs_pkg::KIND_CLEAR, '0, 1'b1, '0, '0, '0, 0, NO_FRAME));
        dir_rows.push_back(row(pcfs_pkg::KIND_TICK, 32'd0, 1'b1, '0, '0, '0, 0, NO_FRAME));
        // Fill the table past its depth; the last add is dropped.
        for (int i = 0; i <= TABLE_DEPTH; i++) begin
            dir_rows.push_back(row(pcfs_pkg::KIND_ADD, '0, 1'b0,
                                   {$urandom} ^ (32'h1 << (i % 32)),
                                   pcfs_pkg::PER_W'(i), {$urandom, $urandom}, 0, NO_FRAME));
        end
        // Every entry is due at once: the widest burst.
        dir_rows.push_back(row(pcfs_pkg::KIND_TICK, 32'h7fff_ffff, 1'b1, '0, '0, '0, -1,
                               NO_FRAME));
        dir_rows.push_back(row(pcfs_pkg::KIND_TICK, 32'h7fff_ffff, 1'b1, '0, '0, '0, -1,
                               NO_FRAME));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            issue(dir_rows[i].item, dir_rows[i].want_n, dir_rows[i].want_frame, 0);
        end
        wait_idle();

        // Random phases: no idling, sender idle 75 %, no idling again (the
        // receiver cannot stall), sender idle 32 %.
        idle_pct = '{0, 75, 0, 32};
        counted = 0;
        sim_ms = 32'd0;
        for (int p = 0; p < 4; p++) begin
            while (counted < (p + 1) * RANDOM_ITEMS / 4) begin
                r = $urandom_range(99);
                it.kind      = (r < 60) ? pcfs_pkg::KIND_TICK :
                               (r < 94) ? pcfs_pkg::KIND_ADD :
                               (r < 97) ? pcfs_pkg::KIND_CLEAR : KIND_UNUSED;
                it.ign       = ($urandom_range(99) < 88);
                it.raw_id    = $urandom;
                it.payload   = {$urandom, $urandom};
                r = $urandom_range(99);
                it.period_ms = (r < 85) ? pcfs_pkg::PER_W'($urandom_range(0, 40)) :
                               (r < 95) ? pcfs_pkg::PER_W'($urandom_range(0, 9999)) :
                                          pcfs_pkg::PER_W'($urandom_range(10000, 16383));
                // Ticks mostly walk forward in small steps; now and then time jumps.
                if (it.kind == pcfs_pkg::KIND_TICK) begin
                    if ($urandom_range(19) == 0) sim_ms = $urandom;
                    else sim_ms = sim_ms + pcfs_pkg::TIME_W'($urandom_range(0, 25));
                    it.now_ms = sim_ms;
                end else begin
                    it.now_ms = $urandom;
                end
                gap = 0;
                while (gap < MAX_GAP && $urandom_range(99) < idle_pct[p]) gap++;
                issue(it, -1, NO_FRAME, gap);
                if (it.kind != KIND_UNUSED) counted++;
            end
            wait_idle();
        end

        repeat (TABLE_DEPTH + 4) @(posedge i_clk);
        if (frames_due.size() != 0) begin
            $error("%0d predicted frames never arrived", frames_due.size());
            err_cnt++;
        end
        $display("Run covered %0d ticks, %0d adds, %0d clears and %0d unused items.",
                 n_ticks, n_adds, n_clears, n_unused);
        $display("%0d frames were checked; the widest tick sent %0d.", frames_seen,
                 widest_burst);
        if (err_cnt == 0) begin
            $display("periodic_can_frame_scheduler_core: match");
        end else begin
            $display("periodic_can_frame_scheduler_core: mismatch");
        end
        $finish;
    end

endmodule
